### sv/owut_pkg.sv
// Shared types and codes of the 1-Wire over UART transaction engine.
package owut_pkg;

    localparam logic [2:0] REQ_LOAD     = 3'd0;
    localparam logic [2:0] REQ_START    = 3'd1;
    localparam logic [2:0] REQ_CHAR     = 3'd2;
    localparam logic [2:0] REQ_LINE_ERR = 3'd3;
    localparam logic [2:0] REQ_RX_TMO   = 3'd4;
    localparam logic [2:0] REQ_TICK     = 3'd5;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_LINE  = 2'd2;
    localparam logic [1:0] ERR_WDOG  = 2'd3;

    localparam logic [7:0] RESET_CHAR = 8'hF0;
    localparam logic [7:0] SLOT_ONE   = 8'hFF;
    localparam logic [7:0] SLOT_ZERO  = 8'h80;

    localparam logic [15:0] WDOG_RESET   = 16'd50;
    localparam logic [2:0]  SAMPLE_RESET = 3'd1;

    localparam logic CFG_WDOG   = 1'b0;
    localparam logic CFG_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        SRC_ONES,
        SRC_MEM,
        SRC_ZERO
    } t_oct_src;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_SLOTS,
        PH_TAIL
    } t_phase;

    typedef struct packed {
        logic       a_valid;
        logic [1:0] a_kind;
        logic [7:0] a_value;
        logic [7:0] a_index;
        logic       a_rb;
        logic [1:0] a_err;
        logic       oct_valid;
        t_oct_src   oct_src;
        logic       b_valid;
        logic [1:0] b_err;
        logic       presence;
    } t_job;

    typedef struct packed {
        logic       re;
        logic [7:0] pos;
    } t_mem_rd;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [7:0] index;
        logic       rb;
        logic       presence;
        logic [1:0] err;
        logic       last;
    } t_result;

endpackage

### sv/onewire_over_uart_transaction_engine.sv
// Top level of the 1-Wire over UART transaction engine.
//
// Input stream: one request word per handshake; tuser carries the request
// type, tdata the store index, data byte and write/read byte counts.
// Loads go into a synchronous transmit store; a start runs a bus transaction
// (reset character, write bytes, read bytes) driven by echoed UART characters.
// Output stream: result words (UART char to send, read byte, or finish with
// error code); tlast marks the last word caused by one request.
// The request's job is registered in the sequencer, and its first result word
// then in the output register. A request with result words holds the
// sequencer until its last word is written, and the next request is taken
// only after that; requests with no result are taken every cycle while the
// sequencer is idle. The store read for a byte is issued as the request is
// taken, and its data is held for the eight slot characters.
// A stalled receiver holds the output register and the sequencer; input
// tready drops until the pending job is played out.
// Reset clears the transaction state, loads watchdog 50 and sample bit 1,
// and empties the output; the store contents are kept.
module onewire_over_uart_transaction_engine #(
    parameter int TX_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // buffer_index, data_byte, tx_count, rx_count
    input  logic [2:0]  i_s_axis_tuser,   // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_value, byte_index, presence, error_code
    output logic [2:0]  o_m_axis_tuser,   // kind, reset_baud
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import owut_pkg::*;

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    logic          fire;
    logic [3:0]    buffer_index;
    logic [7:0]    data_byte;
    logic [4:0]    tx_count;
    logic [7:0]    rx_count;
    logic [2:0]    req_type;
    logic [AW-1:0] w_idx_map [16];
    t_job          job;
    logic          job_valid;
    t_mem_rd       rd;
    logic [7:0]    mem_data;
    logic          emit_ready;
    t_result       result;

    assign req_type     = i_s_axis_tuser;
    assign buffer_index = i_s_axis_tdata[3:0];
    assign data_byte    = i_s_axis_tdata[11:4];
    assign tx_count     = i_s_axis_tdata[16:12];
    assign rx_count     = i_s_axis_tdata[24:17];

    assign o_s_axis_tready = emit_ready;
    assign fire            = i_s_axis_tvalid && emit_ready;

    for (genvar g = 0; g < 16; g++) begin : g_idx
        assign w_idx_map[g] = AW'(g % TX_DEPTH);
    end

    owut_txmem #(
        .TX_DEPTH (TX_DEPTH),
        .AW       (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (fire && (req_type == REQ_LOAD)),
        .i_waddr (w_idx_map[buffer_index]),
        .i_wdata (data_byte),
        .i_rd    (rd),
        .o_rdata (mem_data)
    );

    owut_ctrl #(
        .TX_DEPTH (TX_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (req_type),
        .i_data_byte (data_byte),
        .i_tx_count  (tx_count),
        .i_rx_count  (rx_count),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_job       (job),
        .o_job_valid (job_valid),
        .o_rd        (rd)
    );

    owut_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && job_valid),
        .i_job      (job),
        .i_mem_data (mem_data),
        .i_m_ready  (i_m_axis_tready),
        .o_ready    (emit_ready),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (result)
    );

    assign o_m_axis_tdata = {5'b0, result.err, result.presence, result.index, result.value};
    assign o_m_axis_tuser = {result.rb, result.kind};
    assign o_m_axis_tlast = result.last;

endmodule

### sv/owut_txmem.sv
// Transmit byte store: one write port, one registered read port.
module owut_txmem #(
    parameter int TX_DEPTH = 16,
    parameter int AW       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [7:0]             i_wdata,
    input  owut_pkg::t_mem_rd      i_rd,
    output logic [7:0]             o_rdata
);
    import owut_pkg::*;

    logic [7:0] r_mem [TX_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd.re) begin
            r_rdata <= r_mem[i_rd.pos[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/owut_ctrl.sv
// Transaction state, configuration registers and per-word result job decode.
module owut_ctrl #(
    parameter int TX_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [2:0]         i_req,
    input  logic [7:0]         i_data_byte,
    input  logic [4:0]         i_tx_count,
    input  logic [7:0]         i_rx_count,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    output owut_pkg::t_job     o_job,
    output logic               o_job_valid,
    output owut_pkg::t_mem_rd  o_rd
);
    import owut_pkg::*;

    logic [4:0]  r_wcount, n_wcount;
    logic [7:0]  r_rcount, n_rcount;
    logic [7:0]  r_byte_pos, n_byte_pos;
    logic        r_writing, n_writing;
    logic        r_in_reset, n_in_reset;
    logic        r_busy, n_busy;
    logic [2:0]  r_slot, n_slot;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_tick, n_tick;
    logic        r_present, n_present;
    logic [15:0] r_wdog;
    logic [2:0]  r_sample;

    t_job    job;
    logic    job_valid;
    t_mem_rd rd;
    logic    do_oct;
    logic [7:0] shift_c;
    logic [2:0] slot_c;
    logic [7:0] pos_c;

    always_comb begin
        n_wcount   = r_wcount;
        n_rcount   = r_rcount;
        n_byte_pos = r_byte_pos;
        n_writing  = r_writing;
        n_in_reset = r_in_reset;
        n_busy     = r_busy;
        n_slot     = r_slot;
        n_shift    = r_shift;
        n_tick     = r_tick;
        n_present  = r_present;
        job        = '0;
        job_valid  = 1'b0;
        rd         = '0;
        do_oct     = 1'b0;
        shift_c    = {i_data_byte[r_sample], r_shift[7:1]};
        slot_c     = r_slot + 3'd1;
        pos_c      = r_byte_pos + 8'd1;

        if (i_fire) begin
            case (i_req)
                REQ_START: begin
                    job_valid = 1'b1;
                    job.a_valid = 1'b1;
                    n_present = 1'b0;
                    if ((i_tx_count == 5'd0) && (i_rx_count == 8'd0)) begin
                        n_busy      = 1'b0;
                        n_in_reset  = 1'b0;
                        job.a_kind  = KIND_DONE;
                        job.a_err   = ERR_EMPTY;
                    end else begin
                        n_wcount   = ({4'b0, i_tx_count} > 9'(TX_DEPTH)) ?
                                     5'(TX_DEPTH) : i_tx_count;
                        n_rcount   = i_rx_count;
                        n_writing  = (i_tx_count != 5'd0);
                        n_byte_pos = 8'd0;
                        n_in_reset = 1'b1;
                        n_busy     = 1'b1;
                        n_tick     = 16'd0;
                        n_slot     = 3'd0;
                        n_shift    = 8'd0;
                        job.a_kind  = KIND_CHAR;
                        job.a_value = RESET_CHAR;
                        job.a_rb    = 1'b1;
                    end
                end
                REQ_CHAR: begin
                    if (r_busy) begin
                        if (r_in_reset) begin
                            n_in_reset = 1'b0;
                            n_present  = (i_data_byte != RESET_CHAR);
                            do_oct     = 1'b1;
                        end else begin
                            n_shift = shift_c;
                            n_slot  = slot_c;
                            if (slot_c == 3'd0) begin
                                job_valid = 1'b1;
                                if (r_writing) begin
                                    if ({3'b0, r_wcount} == r_byte_pos) begin
                                        if (r_rcount != 8'd0) begin
                                            n_writing  = 1'b0;
                                            n_byte_pos = 8'd0;
                                            do_oct     = 1'b1;
                                        end else begin
                                            n_busy      = 1'b0;
                                            n_in_reset  = 1'b0;
                                            job.a_valid = 1'b1;
                                            job.a_kind  = KIND_DONE;
                                            job.a_err   = ERR_OK;
                                        end
                                    end else begin
                                        do_oct = 1'b1;
                                    end
                                end else begin
                                    job.a_valid = 1'b1;
                                    job.a_kind  = KIND_BYTE;
                                    job.a_value = shift_c;
                                    job.a_index = r_byte_pos;
                                    n_byte_pos  = pos_c;
                                    if (pos_c == r_rcount) begin
                                        n_busy      = 1'b0;
                                        n_in_reset  = 1'b0;
                                        job.b_valid = 1'b1;
                                        job.b_err   = ERR_OK;
                                    end else begin
                                        do_oct = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                REQ_LINE_ERR, REQ_RX_TMO: begin
                    if (r_busy) begin
                        job_valid   = 1'b1;
                        n_busy      = 1'b0;
                        n_in_reset  = 1'b0;
                        job.a_valid = 1'b1;
                        job.a_kind  = KIND_DONE;
                        job.a_err   = (i_req == REQ_LINE_ERR) ? ERR_LINE : ERR_EMPTY;
                    end
                end
                REQ_TICK: begin
                    if (r_busy) begin
                        if (r_tick >= r_wdog) begin
                            job_valid   = 1'b1;
                            n_busy      = 1'b0;
                            n_in_reset  = 1'b0;
                            job.a_valid = 1'b1;
                            job.a_kind  = KIND_DONE;
                            job.a_err   = ERR_WDOG;
                        end else begin
                            n_tick = r_tick + 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_oct) begin
            job_valid     = 1'b1;
            job.oct_valid = 1'b1;
            n_slot        = 3'd0;
            n_shift       = 8'd0;
            if (n_writing) begin
                if ({1'b0, n_byte_pos} < 9'(TX_DEPTH)) begin
                    rd.re       = 1'b1;
                    rd.pos      = n_byte_pos;
                    job.oct_src = SRC_MEM;
                end else begin
                    job.oct_src = SRC_ZERO;
                end
                n_byte_pos = n_byte_pos + 8'd1;
            end else begin
                job.oct_src = SRC_ONES;
            end
        end
        job.presence = n_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount   <= '0;
            r_rcount   <= '0;
            r_byte_pos <= '0;
            r_writing  <= 1'b0;
            r_in_reset <= 1'b0;
            r_busy     <= 1'b0;
            r_slot     <= '0;
            r_shift    <= '0;
            r_tick     <= '0;
            r_present  <= 1'b0;
            r_wdog     <= WDOG_RESET;
            r_sample   <= SAMPLE_RESET;
        end else begin
            r_wcount   <= n_wcount;
            r_rcount   <= n_rcount;
            r_byte_pos <= n_byte_pos;
            r_writing  <= n_writing;
            r_in_reset <= n_in_reset;
            r_busy     <= n_busy;
            r_slot     <= n_slot;
            r_shift    <= n_shift;
            r_tick     <= n_tick;
            r_present  <= n_present;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WDOG:   r_wdog   <= i_cfg_wdata;
                    CFG_SAMPLE: r_sample <= i_cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_job       = job;
    assign o_job_valid = job_valid;
    assign o_rd        = rd;

endmodule

### sv/owut_emit.sv
// Result sequencer: plays out one job word by word into the output register.
module owut_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  owut_pkg::t_job     i_job,
    input  logic [7:0]         i_mem_data,
    input  logic               i_m_ready,
    output logic               o_ready,
    output logic               o_valid,
    output owut_pkg::t_result  o_result
);
    import owut_pkg::*;

    t_phase     r_phase, n_phase;
    logic [2:0] r_bit, n_bit;
    t_job       r_job;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       emit;
    t_result    res;
    logic [7:0] oct_data;

    assign advance = !r_out_valid || i_m_ready;

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        case (r_phase)
            PH_IDLE: begin
                if (i_load) begin
                    n_bit   = 3'd0;
                    n_phase = i_job.a_valid ? PH_HEAD :
                              i_job.oct_valid ? PH_SLOTS : PH_TAIL;
                end
            end
            PH_HEAD: begin
                if (advance) begin
                    n_bit   = 3'd0;
                    n_phase = r_job.oct_valid ? PH_SLOTS :
                              r_job.b_valid ? PH_TAIL : PH_IDLE;
                end
            end
            PH_SLOTS: begin
                if (advance) begin
                    if (r_bit == 3'd7) begin
                        n_phase = r_job.b_valid ? PH_TAIL : PH_IDLE;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end
            end
            PH_TAIL: begin
                if (advance) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_job.oct_src)
            SRC_MEM:  oct_data = i_mem_data;
            SRC_ZERO: oct_data = 8'h00;
            default:  oct_data = SLOT_ONE;
        endcase
        res          = '0;
        res.presence = r_job.presence;
        emit         = advance && (r_phase != PH_IDLE);
        case (r_phase)
            PH_HEAD: begin
                res.kind  = r_job.a_kind;
                res.value = r_job.a_value;
                res.index = r_job.a_index;
                res.rb    = r_job.a_rb;
                res.err   = r_job.a_err;
            end
            PH_SLOTS: begin
                res.kind  = KIND_CHAR;
                res.value = oct_data[r_bit] ? SLOT_ONE : SLOT_ZERO;
            end
            PH_TAIL: begin
                res.kind = KIND_DONE;
                res.err  = r_job.b_err;
            end
            default: begin
            end
        endcase
        res.last = (n_phase == PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (r_phase == PH_IDLE)) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_ready  = (r_phase == PH_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### sv/owut_chk.sv
// Port-level checker for the transaction engine, bound to the top level.
module owut_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import owut_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == KIND_DONE) |->
            (o_m_axis_tdata[15:0] == 16'd0) && !o_m_axis_tuser[2] && o_m_axis_tlast)
        else $error("finish word carries data or is not last");

    a_reset_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2] |->
            (o_m_axis_tuser[1:0] == KIND_CHAR) && (o_m_axis_tdata[7:0] == RESET_CHAR)
            && o_m_axis_tlast && !o_m_axis_tdata[16])
        else $error("bad reset character word");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[18:17] != ERR_OK) |->
            (o_m_axis_tuser[1:0] == KIND_DONE))
        else $error("error code on a non-finish word");

endmodule

bind onewire_over_uart_transaction_engine owut_chk u_chk (.*);

### tb/tb_onewire_over_uart_transaction_engine.sv
// Self-checking testbench of the 1-Wire over UART transaction engine.
`timescale 1ns / 100ps

module tb_onewire_over_uart_transaction_engine;
    import owut_pkg::*;

    localparam logic [2:0] REQ_BAD_6 = 3'd6;
    localparam logic [2:0] REQ_BAD_7 = 3'd7;
    localparam int STORE_DEPTH = 16;
    localparam int PLAN_ROWS = 19;
    localparam int PHASES = 6;
    localparam int WORK_TARGET = 380;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0] req;
        logic [3:0] bidx;
        logic [7:0] data;
        logic [4:0] txc;
        logic [7:0] rxc;
        logic [3:0] reps;
        logic       typed;
        logic       has_word;
        logic [1:0] kind;
        logic [7:0] value;
        logic       rb;
        logic [1:0] err;
    } t_step_row;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic [2:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    int cycle;
    int mismatches;
    int work_items;

    // bus engine image
    logic [7:0]  store [STORE_DEPTH];
    logic [15:0] loaded;
    logic [4:0]  w_cnt;
    logic [7:0]  r_cnt;
    logic [7:0]  byte_no;
    logic        writing;
    logic        await_presence;
    logic        active;
    logic [2:0]  slots;
    logic [7:0]  shifter;
    logic [15:0] ticks;
    logic        present;
    logic [15:0] wdog_lim;
    logic [2:0]  samp_sel;
    logic        counted;

    t_result step_words [$];
    t_result pending_words [$];
    t_step_row plan [PLAN_ROWS];

    onewire_over_uart_transaction_engine u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic roll_idle();
        return !(cycle >= 200 && cycle < 400) && ($urandom_range(0, 99) < 7);
    endfunction

    always @(negedge clk) begin
        m_ready <= !roll_idle();
    end

    always @(posedge clk) begin : take_word
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected: tdata %h tuser %h", m_data, m_user);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                if (m_user[1:0] !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_user[1:0]);
                    mismatches++;
                end
                if (m_data[7:0] !== want.value) begin
                    $error("out_value: expected %0h, got %0h", want.value, m_data[7:0]);
                    mismatches++;
                end
                if (m_data[15:8] !== want.index) begin
                    $error("byte_index: expected %0d, got %0d", want.index, m_data[15:8]);
                    mismatches++;
                end
                if (m_user[2] !== want.rb) begin
                    $error("reset_baud: expected %0d, got %0d", want.rb, m_user[2]);
                    mismatches++;
                end
                if (m_data[16] !== want.presence) begin
                    $error("presence: expected %0d, got %0d", want.presence, m_data[16]);
                    mismatches++;
                end
                if (m_data[18:17] !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, m_data[18:17]);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    function automatic void note(input logic [1:0] kind, input logic [7:0] value,
                                 input logic [7:0] index, input logic rb,
                                 input logic [1:0] err);
        t_result w;
        w.kind = kind;
        w.value = value;
        w.index = index;
        w.rb = rb;
        w.presence = present;
        w.err = err;
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void close_out(input logic [1:0] err);
        active = 1'b0;
        await_presence = 1'b0;
        note(KIND_DONE, 8'h00, 8'd0, 1'b0, err);
    endfunction

    function automatic void play_byte();
        logic [7:0] bits;
        bits = 8'hFF;
        if (writing) begin
            bits = store[byte_no[3:0]];
            byte_no = byte_no + 8'd1;
        end
        slots = 3'd0;
        shifter = 8'd0;
        for (int i = 0; i < 8; i++)
            note(KIND_CHAR, bits[i] ? SLOT_ONE : SLOT_ZERO, 8'd0, 1'b0, ERR_OK);
    endfunction

    function automatic void engine_step(input logic [2:0] req, input logic [3:0] bidx,
                                        input logic [7:0] data, input logic [4:0] txc,
                                        input logic [7:0] rxc);
        t_result w;
        step_words.delete();
        counted = (req == REQ_LOAD) || (req == REQ_START) ||
                  (active && req >= REQ_CHAR && req <= REQ_TICK);
        case (req)
            REQ_LOAD: begin
                store[bidx] = data;
                loaded[bidx] = 1'b1;
            end
            REQ_START: begin
                if (txc == 5'd0 && rxc == 8'd0) begin
                    present = 1'b0;
                    close_out(ERR_EMPTY);
                end else begin
                    w_cnt = (txc > 5'd16) ? 5'd16 : txc;
                    r_cnt = rxc;
                    writing = (txc != 5'd0);
                    byte_no = 8'd0;
                    present = 1'b0;
                    await_presence = 1'b1;
                    active = 1'b1;
                    ticks = 16'd0;
                    slots = 3'd0;
                    shifter = 8'd0;
                    note(KIND_CHAR, RESET_CHAR, 8'd0, 1'b1, ERR_OK);
                end
            end
            REQ_CHAR: begin
                if (active && await_presence) begin
                    await_presence = 1'b0;
                    present = (data != RESET_CHAR);
                    play_byte();
                end else if (active) begin
                    shifter = {data[samp_sel], shifter[7:1]};
                    slots = slots + 3'd1;
                    if (slots == 3'd0) begin
                        if (writing) begin
                            if (byte_no == {3'd0, w_cnt}) begin
                                if (r_cnt != 8'd0) begin
                                    writing = 1'b0;
                                    byte_no = 8'd0;
                                    play_byte();
                                end else begin
                                    close_out(ERR_OK);
                                end
                            end else begin
                                play_byte();
                            end
                        end else begin
                            note(KIND_BYTE, shifter, byte_no, 1'b0, ERR_OK);
                            byte_no = byte_no + 8'd1;
                            if (byte_no == r_cnt)
                                close_out(ERR_OK);
                            else
                                play_byte();
                        end
                    end
                end
            end
            REQ_LINE_ERR: if (active) close_out(ERR_LINE);
            REQ_RX_TMO: if (active) close_out(ERR_EMPTY);
            REQ_TICK: begin
                if (active) begin
                    if (ticks >= wdog_lim)
                        close_out(ERR_WDOG);
                    else
                        ticks = ticks + 16'd1;
                end
            end
            default: ;
        endcase
        if (step_words.size() != 0) begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
    endfunction

    task automatic send_word(input logic [2:0] req, input logic [3:0] bidx,
                             input logic [7:0] data, input logic [4:0] txc,
                             input logic [7:0] rxc);
        @(negedge clk);
        while (roll_idle()) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user <= req;
        s_data <= {7'd0, rxc, txc, data, bidx};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    task automatic issue(input logic [2:0] req, input logic [3:0] bidx,
                         input logic [7:0] data, input logic [4:0] txc,
                         input logic [7:0] rxc);
        send_word(req, bidx, data, txc, rxc);
        engine_step(req, bidx, data, txc, rxc);
        foreach (step_words[i]) pending_words.push_back(step_words[i]);
        if (counted) work_items++;
    endtask

    task automatic issue_rand(input logic [2:0] req);
        issue(req, 4'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    // fill every store entry the write phase will read before starting
    task automatic open_transaction(input logic [4:0] txc, input logic [7:0] rxc);
        int need;
        need = (txc > 5'd16) ? STORE_DEPTH : int'(txc);
        for (int i = 0; i < need; i++)
            if (!loaded[i]) issue(REQ_LOAD, 4'(i), 8'($urandom), 5'($urandom), 8'($urandom));
        issue(REQ_START, 4'($urandom), 8'($urandom), txc, rxc);
    endtask

    task automatic run_transaction();
        logic [4:0] txc;
        logic [7:0] rxc;
        logic [7:0] echo;
        int roll;
        int echoes;
        int cutoff;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            txc = 5'($urandom_range(0, 16));
        else if (roll < 13)
            txc = 5'($urandom_range(17, 31));
        else
            txc = 5'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 10)
            rxc = 8'($urandom);
        else
            rxc = 8'($urandom_range(0, 2));
        cutoff = (txc > 5'd3 || rxc > 8'd3) ? $urandom_range(0, 40) : 1000;
        open_transaction(txc, rxc);
        echoes = 0;
        while (active) begin
            roll = $urandom_range(0, 99);
            if (echoes >= cutoff) begin
                issue_rand(roll < 50 ? REQ_LINE_ERR : REQ_RX_TMO);
            end else if (roll < 5) begin
                issue_rand(REQ_TICK);
            end else if (roll < 7) begin
                issue_rand(REQ_LOAD);
            end else if (roll < 8) begin
                issue_rand(REQ_LINE_ERR);
            end else if (roll < 9) begin
                issue_rand(REQ_RX_TMO);
            end else if (roll < 10) begin
                issue_rand(roll[0] ? REQ_BAD_7 : REQ_BAD_6);
            end else begin
                echo = 8'($urandom);
                if (await_presence && $urandom_range(0, 1) == 0)
                    echo = RESET_CHAR;
                issue(REQ_CHAR, 4'($urandom), echo, 5'($urandom), 8'($urandom));
                echoes++;
            end
        end
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_WDOG)
            wdog_lim = value;
        else
            samp_sel = value[2:0];
    endtask

    task automatic drain();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_step_row mk_row(
        input logic [2:0] req, input logic [3:0] bidx, input logic [7:0] data,
        input logic [4:0] txc, input logic [7:0] rxc, input logic [3:0] reps,
        input logic typed, input logic has_word, input logic [1:0] kind,
        input logic [7:0] value, input logic rb, input logic [1:0] err);
        t_step_row r;
        r.req = req;
        r.bidx = bidx;
        r.data = data;
        r.txc = txc;
        r.rxc = rxc;
        r.reps = reps;
        r.typed = typed;
        r.has_word = has_word;
        r.kind = kind;
        r.value = value;
        r.rb = rb;
        r.err = err;
        return r;
    endfunction

    initial begin : stimulus
        t_step_row row;
        t_result typed_word;
        logic [2:0] req;
        logic [15:0] wd;
        logic [2:0] sb;

        clk = 1'b0;
        rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = 32'd0;
        s_user = REQ_LOAD;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_WDOG;
        cfg_wdata = 16'd0;
        cycle = 0;
        mismatches = 0;
        work_items = 0;
        loaded = 16'd0;
        for (int i = 0; i < STORE_DEPTH; i++) store[i] = 8'd0;
        w_cnt = 5'd0;
        r_cnt = 8'd0;
        byte_no = 8'd0;
        writing = 1'b0;
        await_presence = 1'b0;
        active = 1'b0;
        slots = 3'd0;
        shifter = 8'd0;
        ticks = 16'd0;
        present = 1'b0;
        wdog_lim = WDOG_RESET;
        samp_sel = SAMPLE_RESET;
        counted = 1'b0;

        plan[0]  = mk_row(REQ_START, 4'd0, 8'h00, 5'd0, 8'd0, 4'd1,
                          1'b1, 1'b1, KIND_DONE, 8'h00, 1'b0, ERR_EMPTY);
        plan[1]  = mk_row(REQ_TICK, 4'd7, 8'h3C, 5'd3, 8'd9, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[2]  = mk_row(REQ_CHAR, 4'd15, 8'hFF, 5'd31, 8'd255, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[3]  = mk_row(REQ_LINE_ERR, 4'd0, 8'h00, 5'd0, 8'd0, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[4]  = mk_row(REQ_RX_TMO, 4'd9, 8'h81, 5'd16, 8'd128, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[5]  = mk_row(REQ_BAD_6, 4'd3, 8'h12, 5'd1, 8'd1, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[6]  = mk_row(REQ_BAD_7, 4'd12, 8'hED, 5'd2, 8'd2, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[7]  = mk_row(REQ_LOAD, 4'd0, 8'h5A, 5'd0, 8'd0, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[8]  = mk_row(REQ_LOAD, 4'd15, 8'hFF, 5'd0, 8'd0, 4'd1,
                          1'b1, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[9]  = mk_row(REQ_START, 4'd0, 8'h00, 5'd1, 8'd0, 4'd1,
                          1'b1, 1'b1, KIND_CHAR, RESET_CHAR, 1'b1, ERR_OK);
        plan[10] = mk_row(REQ_CHAR, 4'd0, 8'h00, 5'd0, 8'd0, 4'd1,
                          1'b0, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[11] = mk_row(REQ_CHAR, 4'd0, 8'hFF, 5'd0, 8'd0, 4'd8,
                          1'b0, 1'b0, KIND_CHAR, 8'h00, 1'b0, ERR_OK);
        plan[12] = mk_row(REQ_START, 4'd0, 8'h00, 5'd0, 8'd1, 4'd1,
                          1'b1, 1'b1, KIND_CHAR, RESET_CHAR, 1'b1, ERR_OK);
        plan[13] = mk_row(REQ_LINE_ERR, 4'd0, 8'h00, 5'd0, 8'd0, 4'd1,
                          1'b1, 1'b1, KIND_DONE, 8'h00, 1'b0, ERR_LINE);
        plan[14] = mk_row(REQ_START, 4'd0, 8'h00, 5'd0, 8'd255, 4'd1,
                          1'b1, 1'b1, KIND_CHAR, RESET_CHAR, 1'b1, ERR_OK);
        plan[15] = mk_row(REQ_RX_TMO, 4'd0, 8'h00, 5'd0, 8'd0, 4'd1,
                          1'b1, 1'b1, KIND_DONE, 8'h00, 1'b0, ERR_EMPTY);
        plan[16] = mk_row(REQ_START, 4'd0, 8'h00, 5'd16, 8'd0, 4'd1,
                          1'b1, 1'b1, KIND_CHAR, RESET_CHAR, 1'b1, ERR_OK);
        plan[17] = mk_row(REQ_START, 4'd0, 8'h00, 5'd31, 8'd255, 4'd1,
                          1'b1, 1'b1, KIND_CHAR, RESET_CHAR, 1'b1, ERR_OK);
        plan[18] = mk_row(REQ_LINE_ERR, 4'd0, 8'h00, 5'd0, 8'd0, 4'd1,
                          1'b1, 1'b1, KIND_DONE, 8'h00, 1'b0, ERR_LINE);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            row = plan[r];
            for (int k = 0; k < int'(row.reps); k++) begin
                if (row.typed) begin
                    send_word(row.req, row.bidx, row.data, row.txc, row.rxc);
                    engine_step(row.req, row.bidx, row.data, row.txc, row.rxc);
                    if (row.has_word) begin
                        typed_word.kind = row.kind;
                        typed_word.value = row.value;
                        typed_word.index = 8'd0;
                        typed_word.rb = row.rb;
                        typed_word.presence = 1'b0;
                        typed_word.err = row.err;
                        typed_word.last = 1'b1;
                        pending_words.push_back(typed_word);
                    end
                end else begin
                    issue(row.req, row.bidx, row.data, row.txc, row.rxc);
                end
            end
        end
        drain();

        work_items = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    wd = 16'd0;
                    sb = 3'd0;
                end
                1: begin
                    wd = 16'hFFFF;
                    sb = 3'd7;
                end
                2: begin
                    wd = 16'd3;
                    sb = 3'd3;
                end
                3: begin
                    wd = 16'($urandom_range(0, 8));
                    sb = 3'($urandom);
                end
                4: begin
                    wd = WDOG_RESET;
                    sb = SAMPLE_RESET;
                end
                default: begin
                    wd = 16'($urandom);
                    sb = 3'($urandom);
                end
            endcase
            write_reg(CFG_WDOG, wd);
            write_reg(CFG_SAMPLE, {13'd0, sb});
            while (work_items < (p + 1) * WORK_TARGET / PHASES) begin
                if ($urandom_range(0, 99) < 8) begin
                    req = 3'($urandom);
                    if (req == REQ_START)
                        open_transaction(5'($urandom), 8'($urandom));
                    else
                        issue_rand(req);
                end else begin
                    run_transaction();
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
sv/owut_pkg.sv
sv/owut_txmem.sv
sv/owut_ctrl.sv
sv/owut_emit.sv
sv/onewire_over_uart_transaction_engine.sv
sv/owut_chk.sv
tb/tb_onewire_over_uart_transaction_engine.sv
